@@ hdl/value_frequency_table_assert.svh @@
// Assertion macros for the value frequency table.
// Expects clk and rst_n in the scope of each use.
`ifndef VALUE_FREQUENCY_TABLE_ASSERT_SVH
`define VALUE_FREQUENCY_TABLE_ASSERT_SVH
`ifndef SYNTH
`define VFT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("value_frequency_table: assertion failed");
`define VFT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("value_frequency_table: assertion failed");
`else
`define VFT_ASSERT_NOW(lbl, ante, cons)
`define VFT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ hdl/vft_pkg.sv @@
// Package for the value frequency table: sizes, codes, transaction types
// and field conversion functions. No dependencies.
`default_nettype none
package vft_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int COUNT_BITS    = 16;
  localparam int VALUE_BITS    = 32;
  localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
  localparam int USED_BITS     = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_HIT    = 2'd0,
    ST_NEW    = 2'd1,
    ST_FULL   = 2'd2,
    ST_UNUSED = 2'd3
  } status_t;

  typedef struct packed {
    op_t                operation;
    logic signed [31:0] value;
    logic        [5:0]  read_index;
  } in_item_t;

  typedef struct packed {
    logic        [5:0]  entry_index;
    logic signed [31:0] entry_value;
    logic        [15:0] entry_count;
    status_t            status;
    logic        [6:0]  used_entries;
  } out_item_t;

  function automatic logic [VALUE_BITS-1:0] value_in(input logic signed [31:0] raw);
    logic signed [63:0] wide;
    wide = 64'(raw);
    return wide[VALUE_BITS-1:0];
  endfunction

  function automatic logic signed [31:0] value_out(input logic [VALUE_BITS-1:0] v);
    logic signed [VALUE_BITS-1:0] s;
    logic signed [63:0]           wide;
    s    = v;
    wide = 64'(s);
    return wide[31:0];
  endfunction

  function automatic logic [15:0] count_out(input logic [COUNT_BITS-1:0] c);
    logic [63:0] wide;
    wide = 64'(c);
    return wide[15:0];
  endfunction

  function automatic logic [5:0] index_out(input logic [IDX_BITS-1:0] i);
    logic [63:0] wide;
    wide = 64'(i);
    return wide[5:0];
  endfunction

  function automatic logic [6:0] used_out(input logic [USED_BITS-1:0] u);
    logic [63:0] wide;
    wide = 64'(u);
    return wide[6:0];
  endfunction

endpackage
`default_nettype wire

@@ hdl/value_frequency_table.sv @@
// Value frequency table: distinct values with occurrence counts, in order of
// first appearance, held in two single-port synchronous memories.
// Depends on vft_pkg and value_frequency_table_assert.svh.
//
// Usage: raise start with a transaction on in_item while busy is low. An add
// scans the used entries one per cycle through the read port of the value
// and count memories and stops at a hit; a read fetches one entry, and a read
// beyond the used entries needs no memory access. The result appears on
// out_item for exactly one cycle with out_strobe high, in the cycle after the
// work ends; the receiver cannot hold it off, so it must take every strobe.
// busy falls as the result is registered, so the next transaction may start
// while the strobe is still up. Memory contents need no clearing after reset.
`default_nettype none
module value_frequency_table (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire vft_pkg::in_item_t  in_item,
  output logic                    out_strobe,
  output vft_pkg::out_item_t      out_item
);
  import vft_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_RDOUT = 3'b100
  } state_t;

  state_t                  state_r, state_nxt;
  logic [USED_BITS-1:0]    used_r, used_nxt;
  logic [USED_BITS-1:0]    scan_r, scan_nxt;
  logic                    cmp_vld_r, cmp_vld_nxt;
  logic [IDX_BITS-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic [VALUE_BITS-1:0]   val_r, val_nxt;
  logic                    out_strobe_r, out_strobe_nxt;
  out_item_t               out_r, out_nxt;

  logic [VALUE_BITS-1:0]   vmem [TABLE_ENTRIES];
  logic [COUNT_BITS-1:0]   cmem [TABLE_ENTRIES];
  logic [VALUE_BITS-1:0]   vrd_r;
  logic [COUNT_BITS-1:0]   crd_r;

  logic                    rd_en;
  logic [IDX_BITS-1:0]     rd_addr;
  logic                    wr_en;
  logic                    wr_val_en;
  logic [IDX_BITS-1:0]     wr_addr;
  logic [VALUE_BITS-1:0]   wr_val;
  logic [COUNT_BITS-1:0]   wr_cnt;
  logic [COUNT_BITS-1:0]   cnt_inc;
  logic [63:0]             ridx_wide;
  logic                    ridx_used;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cmem[wr_addr] <= wr_cnt;
      if (wr_val_en) begin
        vmem[wr_addr] <= wr_val;
      end
    end
    if (rd_en) begin
      vrd_r <= vmem[rd_addr];
      crd_r <= cmem[rd_addr];
    end
  end

  assign ridx_wide = 64'(in_item.read_index);
  assign ridx_used = ridx_wide < 64'(used_r);
  assign cnt_inc   = (crd_r == '1) ? crd_r : crd_r + COUNT_BITS'(1);

  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    scan_nxt       = scan_r;
    cmp_vld_nxt    = cmp_vld_r;
    cmp_idx_nxt    = cmp_idx_r;
    val_nxt        = val_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = out_r;
    rd_en          = 1'b0;
    rd_addr        = scan_r[IDX_BITS-1:0];
    wr_en          = 1'b0;
    wr_val_en      = 1'b0;
    wr_addr        = cmp_idx_r;
    wr_val         = val_r;
    wr_cnt         = cnt_inc;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_item.operation == OP_READ) begin
            if (ridx_used) begin
              rd_en       = 1'b1;
              rd_addr     = ridx_wide[IDX_BITS-1:0];
              cmp_idx_nxt = ridx_wide[IDX_BITS-1:0];
              state_nxt   = S_RDOUT;
            end else begin
              out_strobe_nxt       = 1'b1;
              out_nxt.entry_index  = in_item.read_index;
              out_nxt.entry_value  = '0;
              out_nxt.entry_count  = '0;
              out_nxt.status       = ST_UNUSED;
              out_nxt.used_entries = used_out(used_r);
            end
          end else begin
            val_nxt     = value_in(in_item.value);
            scan_nxt    = '0;
            cmp_vld_nxt = 1'b0;
            state_nxt   = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (cmp_vld_r && (vrd_r == val_r)) begin
          wr_en                = 1'b1;
          out_strobe_nxt       = 1'b1;
          out_nxt.entry_index  = index_out(cmp_idx_r);
          out_nxt.entry_value  = value_out(val_r);
          out_nxt.entry_count  = count_out(cnt_inc);
          out_nxt.status       = ST_HIT;
          out_nxt.used_entries = used_out(used_r);
          state_nxt            = S_IDLE;
        end else if (scan_r < used_r) begin
          rd_en       = 1'b1;
          cmp_idx_nxt = scan_r[IDX_BITS-1:0];
          cmp_vld_nxt = 1'b1;
          scan_nxt    = scan_r + USED_BITS'(1);
        end else begin
          out_strobe_nxt      = 1'b1;
          out_nxt.entry_value = value_out(val_r);
          if (used_r < USED_BITS'(TABLE_ENTRIES)) begin
            wr_en                = 1'b1;
            wr_val_en            = 1'b1;
            wr_addr              = used_r[IDX_BITS-1:0];
            wr_cnt               = COUNT_BITS'(1);
            used_nxt             = used_r + USED_BITS'(1);
            out_nxt.entry_index  = index_out(used_r[IDX_BITS-1:0]);
            out_nxt.entry_count  = count_out(COUNT_BITS'(1));
            out_nxt.status       = ST_NEW;
            out_nxt.used_entries = used_out(used_r + USED_BITS'(1));
          end else begin
            out_nxt.entry_index  = '0;
            out_nxt.entry_count  = '0;
            out_nxt.status       = ST_FULL;
            out_nxt.used_entries = used_out(used_r);
          end
          state_nxt = S_IDLE;
        end
      end
      S_RDOUT: begin
        out_strobe_nxt       = 1'b1;
        out_nxt.entry_index  = index_out(cmp_idx_r);
        out_nxt.entry_value  = value_out(vrd_r);
        out_nxt.entry_count  = count_out(crd_r);
        out_nxt.status       = ST_HIT;
        out_nxt.used_entries = used_out(used_r);
        state_nxt            = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      used_r       <= '0;
      cmp_vld_r    <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      used_r       <= used_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r    <= scan_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    val_r     <= val_nxt;
    out_r     <= out_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

`include "value_frequency_table_assert.svh"

  `VFT_ASSERT_NOW(a_used_bound, 1'b1, used_r <= USED_BITS'(TABLE_ENTRIES))
  `VFT_ASSERT_NOW(a_strobe_idle, out_strobe, state_r == S_IDLE)
  `VFT_ASSERT_NOW(a_new_grows, out_strobe && (out_r.status == ST_NEW), used_r == $past(used_r) + USED_BITS'(1))
  `VFT_ASSERT_NEXT(a_start_acts, start && !busy, busy || out_strobe)

endmodule
`default_nettype wire
